>>> rtl/rhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared widths, codes, the division pipeline record and scaling functions.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CH_W     = 12;
    localparam int QUO_W    = 13;
    localparam int HQ_W     = 10;
    localparam int REM_S_W  = 24;
    localparam int REM_H_W  = 22;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    localparam logic [CH_W-1:0] HUE_OFS_RED   = 12'd0;
    localparam logic [CH_W-1:0] HUE_OFS_GREEN = 12'd1365;
    localparam logic [CH_W-1:0] HUE_OFS_BLUE  = 12'd2730;

    typedef struct packed {
        logic [CH_W-1:0]    mx;
        logic [CH_W-1:0]    d;
        logic [REM_S_W-1:0] rs;
        logic [REM_H_W-1:0] rh;
        logic [QUO_W-1:0]   qs;
        logic [QUO_W-1:0]   qh;
        logic               neg;
        logic [1:0]         sel;
        logic               grey;
        logic               last;
    } t_div;

    // Widens a byte to 12 bits as c*4095/255, which equals 16*c + c/17.
    function automatic logic [CH_W-1:0] widen12(input logic [7:0] c);
        logic [19:0] p;
        p = 20'(c) * 20'd3856;
        return {c, 4'b0000} + 12'(p[19:16]);
    endfunction

    // Maps 0..4096 back to a byte as x*255/4095.
    function automatic logic [7:0] scale_to_byte(input logic [QUO_W-1:0] x);
        logic [19:0] p;
        logic [7:0]  qe;
        logic [12:0] rem;
        p   = 20'(x) * 20'd255;
        qe  = p[19:12];
        rem = 13'(qe) + {1'b0, p[11:0]};
        return (rem >= 13'd4095) ? qe + 8'd1 : qe;
    endfunction

endpackage

>>> rtl/rhc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV stream interfaces
// Valid/ready channels for input pixels and for converted results.
// ----------------------------------------------------------------------------
interface rhc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rhc_hsv_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] value_out;
    logic       last_out;
    modport source (output valid, hue, saturation, value_out, last_out, input ready);
    modport sink   (input valid, hue, saturation, value_out, last_out, output ready);
endinterface

>>> rtl/rhc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Three stages: channel widening, min/max and sextant, hue dividend setup.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rhc_pix_if.sink             i_pix,
    output logic                o_valid,
    input  logic                i_ready,
    output rhc_pkg::t_div       o_data
);

    logic [2:0] r_v;
    logic [2:0] w_en;

    logic [11:0] r_r, r_g, r_b;
    logic        r_last0;

    logic [11:0] r_mx1, r_d1, r_n1;
    logic        r_neg1, r_grey1, r_last1;
    logic [1:0]  r_sel1;

    rhc_pkg::t_div r_out;

    logic [11:0] n_mx, n_mn, n_pa, n_pb;
    logic [1:0]  n_sel;
    logic [26:0] w_prod;
    logic [10:0] w_a;
    logic [1:0]  w_b;
    logic [10:0] w_frac;

    assign w_en[2]     = !r_v[2] || i_ready;
    assign w_en[1]     = !r_v[1] || w_en[2];
    assign w_en[0]     = !r_v[0] || w_en[1];
    assign i_pix.ready = w_en[0];

    always_comb begin
        n_mx = r_r;
        if (r_g > n_mx) n_mx = r_g;
        if (r_b > n_mx) n_mx = r_b;
        n_mn = r_r;
        if (r_g < n_mn) n_mn = r_g;
        if (r_b < n_mn) n_mn = r_b;
        if (n_mx == r_r) begin
            n_sel = rhc_pkg::SEL_RED;
            n_pa  = r_g;
            n_pb  = r_b;
        end else if (n_mx == r_g) begin
            n_sel = rhc_pkg::SEL_GREEN;
            n_pa  = r_b;
            n_pb  = r_r;
        end else begin
            n_sel = rhc_pkg::SEL_BLUE;
            n_pa  = r_r;
            n_pb  = r_g;
        end
    end

    // The hue dividend |n|*4096/6 is built as 2048*(n/3) plus 2048*(n%3)/3.
    always_comb begin
        w_prod = 27'(r_n1) * 27'd21846;
        w_a    = w_prod[26:16];
        w_b    = 2'(r_n1 - 12'(w_a) * 12'd3);
        case (w_b)
            2'd1:    w_frac = 11'd682;
            2'd2:    w_frac = 11'd1365;
            default: w_frac = 11'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_pix.valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_r     <= rhc_pkg::widen12(i_pix.red);
            r_g     <= rhc_pkg::widen12(i_pix.green);
            r_b     <= rhc_pkg::widen12(i_pix.blue);
            r_last0 <= i_pix.last_pixel;
        end
        if (w_en[1]) begin
            r_mx1   <= n_mx;
            r_d1    <= n_mx - n_mn;
            r_grey1 <= (n_mx == n_mn);
            r_sel1  <= n_sel;
            r_neg1  <= (n_pa < n_pb);
            r_n1    <= (n_pa >= n_pb) ? n_pa - n_pb : n_pb - n_pa;
            r_last1 <= r_last0;
        end
        if (w_en[2]) begin
            r_out.mx   <= r_mx1;
            r_out.d    <= r_d1;
            r_out.rs   <= {r_d1, 12'd0};
            r_out.rh   <= {w_a, 11'd0} + 22'(w_frac);
            r_out.qs   <= '0;
            r_out.qh   <= '0;
            r_out.neg  <= r_neg1;
            r_out.sel  <= r_sel1;
            r_out.grey <= r_grey1;
            r_out.last <= r_last1;
        end
    end

    assign o_valid = r_v[2];
    assign o_data  = r_out;

endmodule

>>> rtl/rhc_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV division step
// One restoring step of both the saturation and the hue divisions.
// ----------------------------------------------------------------------------
module rhc_div_stage #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rhc_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rhc_pkg::t_div o_data
);

    logic          r_v;
    rhc_pkg::t_div r_d;
    rhc_pkg::t_div n_d;
    logic [24:0]   w_sub_s;
    logic [24:0]   w_sub_h;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        w_sub_s = {1'b0, i_data.rs} - (25'(i_data.mx) << STEP);
        w_sub_h = {3'b000, i_data.rh} - (25'(i_data.d) << STEP);
        n_d     = i_data;
        if (!w_sub_s[24]) begin
            n_d.rs       = w_sub_s[rhc_pkg::REM_S_W-1:0];
            n_d.qs[STEP] = 1'b1;
        end
        if (!w_sub_h[24]) begin
            n_d.rh       = w_sub_h[rhc_pkg::REM_H_W-1:0];
            n_d.qh[STEP] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_d;

endmodule

>>> rtl/rhc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV back end
// Applies the hue sign and sextant offset, then rescales to bytes.
// ----------------------------------------------------------------------------
module rhc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rhc_pkg::t_div i_data,
    rhc_hsv_if.source     o_hsv
);

    logic [1:0]  r_v;
    logic [1:0]  w_en;
    logic [11:0] r_h, r_mx;
    logic [12:0] r_s;
    logic        r_grey, r_last;
    logic [7:0]  r_hue, r_sat, r_val;
    logic        r_last_out;
    logic [11:0] n_off, n_q;

    assign w_en[1] = !r_v[1] || o_hsv.ready;
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_ready = w_en[0];

    always_comb begin
        case (i_data.sel)
            rhc_pkg::SEL_GREEN: n_off = rhc_pkg::HUE_OFS_GREEN;
            rhc_pkg::SEL_BLUE:  n_off = rhc_pkg::HUE_OFS_BLUE;
            default:            n_off = rhc_pkg::HUE_OFS_RED;
        endcase
        n_q = 12'(i_data.qh[rhc_pkg::HQ_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
        end
    end

    // Negative hue wraps by 4096, which is the natural 12-bit wraparound.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_h    <= i_data.neg ? n_off - n_q : n_off + n_q;
            r_s    <= i_data.qs;
            r_mx   <= i_data.mx;
            r_grey <= i_data.grey;
            r_last <= i_data.last;
        end
        if (w_en[1]) begin
            r_last_out <= r_last;
            if (r_grey) begin
                r_hue <= '0;
                r_sat <= '0;
                r_val <= r_mx[11:4];
            end else begin
                r_hue <= rhc_pkg::scale_to_byte({1'b0, r_h});
                r_sat <= rhc_pkg::scale_to_byte(r_s);
                r_val <= rhc_pkg::scale_to_byte({1'b0, r_mx});
            end
        end
    end

    assign o_hsv.valid      = r_v[1];
    assign o_hsv.hue        = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.value_out  = r_val;
    assign o_hsv.last_out   = r_last_out;

endmodule

>>> rtl/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts 8-bit RGB pixels to 8-bit hue, saturation and value.
// ----------------------------------------------------------------------------
// The converter accepts one pixel per clock and delivers one result per
// clock in steady state while the output is not stalled. The depth is
// set by the two long divisions, which run side by side as 13 restoring
// steps, one per pipeline stage, between three front-end and two back-end
// stages. Each stage holds its transaction when the next one is full, so
// a stalled output fills the pipeline before the input ready falls.
module rgb_to_hsv_converter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhc_pix_if.sink   i_pix,
    rhc_hsv_if.source o_hsv
);

    localparam int N = rhc_pkg::DIV_STEPS;

    logic          w_v   [N+1];
    logic          w_rdy [N+1];
    rhc_pkg::t_div w_d   [N+1];

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_valid (w_v[0]),
        .i_ready (w_rdy[0]),
        .o_data  (w_d[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_div
        rhc_div_stage #(.STEP(N - 1 - k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_data  (w_d[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_data  (w_d[k+1])
        );
    end

    rhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[N]),
        .o_ready (w_rdy[N]),
        .i_data  (w_d[N]),
        .o_hsv   (o_hsv)
    );

endmodule

>>> rtl/rhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV port checker
// Checks reset behavior, output holding and flow control at the ports.
// ----------------------------------------------------------------------------
module rhc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_hue,
    input logic [7:0] i_sat,
    input logic [7:0] i_val,
    input logic       i_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("Output valid after reset.");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Output transaction dropped while stalled.");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_hue) && $stable(i_sat) && $stable(i_val) && $stable(i_last))
        else $error("Output payload changed while stalled.");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("Input stalled while the output side is ready.");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_hsv.valid),
    .i_out_ready (o_hsv.ready),
    .i_hue       (o_hsv.hue),
    .i_sat       (o_hsv.saturation),
    .i_val       (o_hsv.value_out),
    .i_last      (o_hsv.last_out)
);
